/* hdl/swms_pkg.sv */
// shared types, constants and helpers for the running median smoother
`default_nettype none

package swms_pkg;

    localparam int MAX_WINDOW = 31;
    localparam int W_BITS     = 5;
    localparam int DATA_BITS  = 32;
    localparam int NUM_CELLS  = MAX_WINDOW;
    localparam int HIST_DEPTH = MAX_WINDOW + 1;
    localparam int MED_DEPTH  = MAX_WINDOW / 2 + 1;
    localparam int H_BITS     = $clog2(MED_DEPTH);
    localparam int HIST_BITS  = $clog2(HIST_DEPTH);
    localparam int CNT_BITS   = W_BITS + 1;

    localparam logic [W_BITS-1:0]   WINDOW_RESET = W_BITS'(5);
    localparam logic [CNT_BITS-1:0] COUNT_MAX    = {CNT_BITS{1'b1}};

    // one cell's view as seen by its neighbors
    typedef struct packed {
        logic                        valid;
        logic                        le;
        logic signed [DATA_BITS-1:0] value;
        logic [W_BITS-1:0]           age;
    } t_link;

    // zero acts as one, anything above the cell count is clamped
    function automatic logic [W_BITS-1:0] effective_window(input logic [W_BITS-1:0] reg_w);
        logic [W_BITS-1:0] w;
        w = reg_w;
        if (w == '0) begin
            w = W_BITS'(1);
        end
        if (w > W_BITS'(MAX_WINDOW)) begin
            w = W_BITS'(MAX_WINDOW);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* hdl/swms_cell.sv */
// one cell of the sorted window: holds a sample and its age, shifts with neighbors
`default_nettype none

module swms_cell (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_load,
    input  wire logic                                  i_clear,
    input  wire logic signed [swms_pkg::DATA_BITS-1:0] i_x,
    input  wire logic [swms_pkg::W_BITS-1:0]           i_w_last,
    input  wire logic                                  i_below,
    input  wire swms_pkg::t_link                       i_lower,
    input  wire swms_pkg::t_link                       i_upper,
    output swms_pkg::t_link                            o_link,
    output logic                                       o_below
);
    import swms_pkg::*;

    logic                        r_valid;
    logic signed [DATA_BITS-1:0] r_value;
    logic [W_BITS-1:0]           r_age;

    logic                        n_valid;
    logic signed [DATA_BITS-1:0] n_value;
    logic [W_BITS-1:0]           n_age;

    logic  valid_eff;
    logic  del;
    t_link self_link;
    t_link cur;
    t_link prv;

    assign valid_eff = r_valid & ~i_clear;
    assign del       = valid_eff && (r_age == i_w_last);

    always_comb begin
        self_link.valid = valid_eff;
        self_link.le    = valid_eff && (r_value <= i_x);
        self_link.value = r_value;
        self_link.age   = r_age;
    end

    assign o_link  = self_link;
    assign o_below = i_below | del;

    // view after removing the expiring sample
    assign cur = (i_below | del) ? i_upper : self_link;
    assign prv = i_below ? self_link : i_lower;

    always_comb begin
        if (cur.le) begin
            n_valid = 1'b1;
            n_value = cur.value;
            n_age   = cur.age + W_BITS'(1);
        end else if (prv.le) begin
            n_valid = 1'b1;
            n_value = i_x;
            n_age   = '0;
        end else begin
            n_valid = prv.valid;
            n_value = prv.value;
            n_age   = prv.age + W_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule

`default_nettype wire

/* hdl/swms_sorter.sv */
// row of cells keeping the current window sorted, with the median tap
`default_nettype none

module swms_sorter (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_load,
    input  wire logic                                  i_clear,
    input  wire logic signed [swms_pkg::DATA_BITS-1:0] i_x,
    input  wire logic [swms_pkg::W_BITS-1:0]           i_w_last,
    input  wire logic [swms_pkg::H_BITS-1:0]           i_half,
    output logic signed [swms_pkg::DATA_BITS-1:0]      o_median
);
    import swms_pkg::*;

    t_link                       links [NUM_CELLS];
    logic                        below [NUM_CELLS+1];
    logic signed [DATA_BITS-1:0] taps  [MED_DEPTH];
    t_link                       floor_link;
    t_link                       ceil_link;

    // below the first cell everything counts as smaller, above the last is empty
    always_comb begin
        floor_link.valid = 1'b1;
        floor_link.le    = 1'b1;
        floor_link.value = '0;
        floor_link.age   = '0;
        ceil_link.valid  = 1'b0;
        ceil_link.le     = 1'b0;
        ceil_link.value  = '0;
        ceil_link.age    = '0;
    end

    assign below[0] = 1'b0;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        swms_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (i_load),
            .i_clear  (i_clear),
            .i_x      (i_x),
            .i_w_last (i_w_last),
            .i_below  (below[i]),
            .i_lower  ((i == 0) ? floor_link : links[(i == 0) ? 0 : i-1]),
            .i_upper  ((i == NUM_CELLS-1) ? ceil_link
                                          : links[(i == NUM_CELLS-1) ? i : i+1]),
            .o_link   (links[i]),
            .o_below  (below[i+1])
        );
    end

    for (genvar k = 0; k < MED_DEPTH; k++) begin : g_tap
        assign taps[k] = links[k].value;
    end

    assign o_median = taps[i_half];

endmodule

`default_nettype wire

/* hdl/sliding_window_median_smoother_core.sv */
// running median smoother top level: sorted cell row, history, flush sequencer
// a non-final sample that yields a word moves the sequencer to the emit state, and the
//   word enters the output register once the output is free; new samples are taken only
//   when idle; the final sample of a track flushes one word per pending position
// reset: synchronous active low, window register back to 5, cells emptied,
//   sample count cleared; history and median lines are not cleared
`default_nettype none

module sliding_window_median_smoother_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [swms_pkg::W_BITS-1:0]           i_window_size,
    // sample input
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [swms_pkg::DATA_BITS-1:0] i_elevation,
    input  wire logic                                  i_last_sample,
    // smoothed output
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [swms_pkg::DATA_BITS-1:0]      o_smoothed,
    output logic                                       o_was_filtered,
    output logic                                       o_last_of_run,
    output logic                                       o_end_of_track
);
    import swms_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    // control
    t_state              r_state;
    t_state              n_state;
    logic [W_BITS-1:0]   r_window;
    logic [W_BITS-1:0]   r_track_w;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic [W_BITS-1:0]   r_back;
    logic [W_BITS-1:0]   n_back;
    logic                r_allow;
    logic                n_allow;
    logic                r_flush;
    logic                n_flush;
    logic                r_out_valid;

    // payload
    logic signed [DATA_BITS-1:0] r_hist [HIST_DEPTH];
    logic signed [DATA_BITS-1:0] r_med  [MED_DEPTH];
    logic signed [DATA_BITS-1:0] r_out_value;
    logic                        r_out_filt;
    logic                        r_out_lor;
    logic                        r_out_eot;

    logic                        in_fire;
    logic                        out_free;
    logic                        emit_fire;
    logic                        track_start;
    logic [W_BITS-1:0]           w_now;
    logic [CNT_BITS-1:0]         count_new;
    logic [H_BITS-1:0]           half;
    logic signed [DATA_BITS-1:0] median;
    logic                        filt;
    logic [CNT_BITS-1:0]         newest_full;
    logic [H_BITS:0]             newest;
    logic [H_BITS-1:0]           med_idx;
    logic signed [DATA_BITS-1:0] med_val;
    logic signed [DATA_BITS-1:0] emit_value;
    logic                        emit_end;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign in_fire     = i_valid & o_ready;
    assign out_free    = ~r_out_valid | i_ready;
    assign emit_fire   = (r_state == S_EMIT) & out_free;

    // the window length is latched with the first sample of each track
    assign track_start = (r_count == '0);
    assign w_now       = track_start ? effective_window(r_window) : r_track_w;
    assign count_new   = (r_count == COUNT_MAX) ? r_count : r_count + CNT_BITS'(1);
    assign half        = r_track_w[W_BITS-1:1];

    // sorted window of the latest samples; cell at rank half is the median
    swms_sorter u_sorter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_fire),
        .i_clear  (track_start),
        .i_x      (i_elevation),
        .i_w_last (w_now - W_BITS'(1)),
        .i_half   (half),
        .o_median (median)
    );

    // word for history position r_back: a median only if its whole window
    // lies inside the track and it is not within half a window of the end
    assign filt = r_allow
               && ({1'b0, half} <= r_back)
               && ((r_count - CNT_BITS'(1)) >= (CNT_BITS'(half) + CNT_BITS'(r_back)));

    // age of the newest sample in that window; zero is the live sorter output,
    // older medians come from the median line
    assign newest_full = CNT_BITS'(r_back) + CNT_BITS'(half) + CNT_BITS'(1)
                       - CNT_BITS'(r_track_w);
    assign newest      = newest_full[H_BITS:0];
    assign med_idx     = newest[H_BITS-1:0] - H_BITS'(1);
    assign med_val     = (newest == '0) ? median : r_med[med_idx];
    assign emit_value  = filt ? med_val : r_hist[r_back];
    assign emit_end    = r_flush && (r_back == '0);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_back  = r_back;
        n_allow = r_allow;
        n_flush = r_flush;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_count = count_new;
                    if (!i_last_sample) begin
                        // one word once the window has filled
                        n_flush = 1'b0;
                        n_allow = 1'b1;
                        n_back  = w_now;
                        if (count_new > CNT_BITS'(w_now)) begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        // final sample flushes every position still pending
                        n_flush = 1'b1;
                        n_state = S_EMIT;
                        if (count_new <= CNT_BITS'(w_now)) begin
                            n_allow = 1'b0;
                            n_back  = W_BITS'(count_new - CNT_BITS'(1));
                        end else begin
                            n_allow = 1'b1;
                            n_back  = w_now;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    if (!r_flush) begin
                        n_state = S_IDLE;
                    end else if (r_back == '0) begin
                        n_state = S_IDLE;
                        n_count = '0;
                    end else begin
                        n_back = r_back - W_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RESET;
            r_track_w   <= WINDOW_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_window <= i_window_size;
            end
            if (in_fire) begin
                r_track_w <= w_now;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        r_back  <= n_back;
        r_allow <= n_allow;
        r_flush <= n_flush;
    end

    // raw history and median line, newest at index zero; the median line
    // takes the window median as it stood before this sample
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hist[0] <= i_elevation;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_med[0] <= median;
            for (int i = 1; i < MED_DEPTH; i++) begin
                r_med[i] <= r_med[i-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_value <= emit_value;
            r_out_filt  <= filt;
            r_out_lor   <= ~r_flush | emit_end;
            r_out_eot   <= emit_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_smoothed     = r_out_value;
    assign o_was_filtered = r_out_filt;
    assign o_last_of_run  = r_out_lor;
    assign o_end_of_track = r_out_eot;

    // a word closing the track also closes its run
    a_eot_is_lor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_track |-> o_last_of_run)
        else $error("end of track word without last of run");

    // the final flush word resets the track count
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire && emit_end |=> (r_count == '0) && (r_state == S_IDLE))
        else $error("track count not cleared after flush");

    // never look further back than the track window
    a_back_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_back <= r_track_w))
        else $error("history position beyond window");

    // a filtered word uses a median no older than half a window plus one
    a_med_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && filt |-> ({1'b0, newest} <= (CNT_BITS'(half) + CNT_BITS'(1))))
        else $error("median line index out of range");

endmodule

`default_nettype wire
